// ===== hdl/gcrm_pkg.sv =====
// Shared constants and defaults for the grid cell revisit monitor.
`timescale 1ns / 1ps

package gcrm_pkg;

  // Default geometry: cells per side of the storage grid and cell size in metres.
  localparam int GRID_SIDE_DEF   = 256;
  localparam int CELL_METRES_DEF = 20;

  // Field widths fixed by the interface.
  localparam int POS_W    = 24;
  localparam int TIME_W   = 40;
  localparam int CHECK_W  = 8;
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 16;
  localparam int SIDE_W   = 9;
  localparam int GAPMIN_W = 16;
  localparam int LIMIT_W  = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // One stored entry holds the visited bit above the last visit time.
  localparam int ENTRY_W = TIME_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 2'd1;

  // Configuration reset values.
  localparam logic [SIDE_W-1:0]   GRID_SIDE_RST = 9'd256;
  localparam logic [GAPMIN_W-1:0] MAX_GAP_RST   = 16'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RECORDED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GAP       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OFF_GRID  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEVER     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STALE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OK        = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CHECK_OFF = 3'd6;

endpackage

// ===== hdl/gcrm_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module gcrm_ram #(
  parameter int WIDTH = gcrm_pkg::ENTRY_W,
  parameter int DEPTH = gcrm_pkg::GRID_SIDE_DEF * gcrm_pkg::GRID_SIDE_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              wr_en,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write on enable, read every cycle into the output register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/grid_cell_revisit_monitor_top.sv =====
// Top level of the grid cell revisit monitor: sequencer, divider and cell store.
`timescale 1ns / 1ps

// The monitor handles one transaction at a time. A position report passes
// through the constant divide of both coordinates (states DIV, BACK and FIX),
// then ADDR forms the cell address, READ reads the RAM and UPD writes back and
// loads the result, holding while a waiting result is stalled; a cell check skips
// the divide. The single-port cell RAM carries one read and at most one write per
// item, so no two accesses to the same cell can overlap. After reset the block
// clears all GRID_SIDE * GRID_SIDE cells (65536 by default) of the cell RAM and
// holds in_stall high until it is done; configuration writes are taken at any time.
// A result waits in the output register while the next transaction is accepted.
module grid_cell_revisit_monitor_top #(
  parameter int GRID_SIDE   = gcrm_pkg::GRID_SIDE_DEF,
  parameter int CELL_METRES = gcrm_pkg::CELL_METRES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [gcrm_pkg::POS_W-1:0]   in_pos_x_m,
  input  logic signed [gcrm_pkg::POS_W-1:0]   in_pos_y_m,
  input  logic [gcrm_pkg::TIME_W-1:0]         in_time_s,
  input  logic [gcrm_pkg::CHECK_W-1:0]        in_check_col,
  input  logic [gcrm_pkg::CHECK_W-1:0]        in_check_row,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gcrm_pkg::KIND_W-1:0]         out_result_kind,
  output logic [gcrm_pkg::INDEX_W-1:0]        out_cell_index,
  output logic [gcrm_pkg::TIME_W-1:0]         out_gap_s,
  output logic                                out_any_violation,
  // Configuration channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcrm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PosW   = gcrm_pkg::POS_W;
  localparam int TimeW  = gcrm_pkg::TIME_W;
  localparam int SideW  = gcrm_pkg::SIDE_W;
  localparam int Depth  = GRID_SIDE * GRID_SIDE;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ColW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int ProdW  = 2 * PosW + 1;

  // Reciprocal of the cell size scaled by 2^PosW; estimate is low by at most one.
  localparam logic [PosW:0]    DivMul    = (PosW+1)'((64'd1 << PosW) / CELL_METRES);
  localparam logic [PosW-1:0]  CellC     = PosW'(CELL_METRES);
  localparam logic [SideW+1:0] GridSideC = (SideW+2)'(GRID_SIDE);
  localparam logic [AddrW-1:0] GridSideA = AddrW'(GRID_SIDE);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(Depth - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_BACK  = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;
  localparam logic [2:0] ST_ADDR  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_UPD   = 3'd7;

  // Control registers.
  logic [2:0]                      state_r, state_nxt;
  logic [AddrW-1:0]                clr_addr_r, clr_addr_nxt;
  logic [SideW-1:0]                grid_side_r, grid_side_nxt;
  logic [gcrm_pkg::GAPMIN_W-1:0]   max_gap_r, max_gap_nxt;
  logic [TimeW-1:0]                latest_r, latest_nxt;
  logic                            violation_r, violation_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Item payload registers.
  logic                            cmd_r, cmd_nxt;
  logic [TimeW-1:0]                time_r, time_nxt;
  logic                            neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [PosW-1:0]                 mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic [PosW-1:0]                 q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [PosW-1:0]                 back_x_r, back_x_nxt, back_y_r, back_y_nxt;
  logic                            off_r, off_nxt;
  logic [AddrW-1:0]                slot_r, slot_nxt;
  logic [gcrm_pkg::INDEX_W-1:0]    idx_r, idx_nxt;

  // Result registers.
  logic [gcrm_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [gcrm_pkg::INDEX_W-1:0]    oidx_r, oidx_nxt;
  logic [TimeW-1:0]                gap_r, gap_nxt;

  // Combinational helpers.
  logic [SideW-1:0]                side;
  logic [gcrm_pkg::LIMIT_W-1:0]    limit;
  logic [ProdW-1:0]                prod_x, prod_y;
  logic [2*PosW-1:0]               back_px, back_py;
  logic [PosW-1:0]                 rem_x, rem_y;
  logic [PosW-1:0]                 pos_x_u, pos_y_u;
  logic [2*SideW-1:0]              row_side;
  logic [AddrW-1:0]                row_a, col_a;
  logic [TimeW-1:0]                prev_t, ref_t, diff_t;
  logic                            prev_vis, ref_gt;
  logic                            upd_go;

  // RAM port signals.
  logic [AddrW-1:0]                ram_addr;
  logic                            ram_we;
  logic [gcrm_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;

  gcrm_ram #(
    .WIDTH (gcrm_pkg::ENTRY_W),
    .DEPTH (Depth)
  ) u_cell_ram (
    .clk     (clk),
    .addr    (ram_addr),
    .wr_en   (ram_we),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // Effective grid side is the smaller of the register and the storage side.
  assign side  = ({2'b00, grid_side_r} < GridSideC) ? grid_side_r : GridSideC[SideW-1:0];
  // Gap limit in seconds: 60 * minutes = 64 * minutes - 4 * minutes.
  assign limit = {max_gap_r, 6'b0} - {4'b0, max_gap_r, 2'b0};

  assign pos_x_u = in_pos_x_m;
  assign pos_y_u = in_pos_y_m;

  // Divider datapath, one multiplier per coordinate in each of the DIV and BACK steps.
  assign prod_x  = ProdW'(mag_x_r) * ProdW'(DivMul);
  assign prod_y  = ProdW'(mag_y_r) * ProdW'(DivMul);
  assign back_px = (2*PosW)'(q_x_r) * (2*PosW)'(CellC);
  assign back_py = (2*PosW)'(q_y_r) * (2*PosW)'(CellC);
  assign rem_x   = mag_x_r - back_x_r;
  assign rem_y   = mag_y_r - back_y_r;

  // Cell index and storage slot of the divided or checked coordinates.
  assign row_side = (2*SideW)'(q_y_r[SideW-1:0]) * (2*SideW)'(side);
  assign row_a    = AddrW'(q_y_r[ColW-1:0]);
  assign col_a    = AddrW'(q_x_r[ColW-1:0]);

  // Gap against the stored visit time; reports use their own time, checks the latest.
  assign prev_vis = ram_rdata[gcrm_pkg::ENTRY_W-1];
  assign prev_t   = ram_rdata[TimeW-1:0];
  assign ref_t    = cmd_r ? latest_r : time_r;
  assign ref_gt   = ref_t > prev_t;
  assign diff_t   = ref_gt ? (ref_t - prev_t) : '0;

  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  // RAM access: clearing sweep, or the current item's slot.
  always_comb begin
    ram_addr  = slot_r;
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_addr = clr_addr_r;
      ram_we   = 1'b1;
    end else if (upd_go && !cmd_r && !off_r) begin
      ram_we    = !prev_vis || ref_gt;
      ram_wdata = {1'b1, time_r};
    end
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    grid_side_nxt = grid_side_r;
    max_gap_nxt   = max_gap_r;
    latest_nxt    = latest_r;
    violation_nxt = violation_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    time_nxt      = time_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    mag_x_nxt     = mag_x_r;
    mag_y_nxt     = mag_y_r;
    q_x_nxt       = q_x_r;
    q_y_nxt       = q_y_r;
    back_x_nxt    = back_x_r;
    back_y_nxt    = back_y_r;
    off_nxt       = off_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    oidx_nxt      = oidx_r;
    gap_nxt       = gap_r;

    // Configuration writes; unknown indexes are dropped.
    if (cfg_valid) begin
      case (cfg_index)
        gcrm_pkg::REG_GRID_SIDE: grid_side_nxt = cfg_wdata[SideW-1:0];
        gcrm_pkg::REG_MAX_GAP:   max_gap_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LastAddr) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          time_nxt  = in_time_s;
          neg_x_nxt = 1'b0;
          neg_y_nxt = 1'b0;
          if (!in_command) begin
            neg_x_nxt = pos_x_u[PosW-1];
            neg_y_nxt = pos_y_u[PosW-1];
            mag_x_nxt = pos_x_u[PosW-1] ? (~pos_x_u + 1'b1) : pos_x_u;
            mag_y_nxt = pos_y_u[PosW-1] ? (~pos_y_u + 1'b1) : pos_y_u;
            state_nxt = ST_DIV;
          end else begin
            q_x_nxt   = PosW'(in_check_col);
            q_y_nxt   = PosW'(in_check_row);
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_DIV: begin
        q_x_nxt   = prod_x[2*PosW-1:PosW];
        q_y_nxt   = prod_y[2*PosW-1:PosW];
        state_nxt = ST_BACK;
      end
      ST_BACK: begin
        back_x_nxt = back_px[PosW-1:0];
        back_y_nxt = back_py[PosW-1:0];
        state_nxt  = ST_FIX;
      end
      ST_FIX: begin
        // Remainder at or above the cell size means the estimate was one short.
        q_x_nxt   = (rem_x >= CellC) ? (q_x_r + 1'b1) : q_x_r;
        q_y_nxt   = (rem_y >= CellC) ? (q_y_r + 1'b1) : q_y_r;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        // A negative coordinate is on the grid only when it truncates to zero.
        off_nxt = (neg_x_r && (q_x_r != '0)) || (neg_y_r && (q_y_r != '0)) ||
                  (q_x_r >= PosW'(side)) || (q_y_r >= PosW'(side));
        slot_nxt  = off_nxt ? '0 : (row_a * GridSideA + col_a);
        idx_nxt   = row_side[gcrm_pkg::INDEX_W-1:0] +
                    gcrm_pkg::INDEX_W'(q_x_r[SideW-1:0]);
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          oidx_nxt      = idx_r;
          gap_nxt       = '0;
          if (!cmd_r) begin
            // Position report.
            if (time_r > latest_r) begin
              latest_nxt = time_r;
            end
            if (off_r) begin
              kind_nxt = gcrm_pkg::KIND_OFF_GRID;
              oidx_nxt = '0;
            end else if (!prev_vis) begin
              kind_nxt = gcrm_pkg::KIND_RECORDED;
            end else begin
              gap_nxt = diff_t;
              if (diff_t >= TimeW'(limit)) begin
                kind_nxt      = gcrm_pkg::KIND_GAP;
                violation_nxt = 1'b1;
              end else begin
                kind_nxt = gcrm_pkg::KIND_RECORDED;
              end
            end
          end else begin
            // Cell check.
            if (off_r) begin
              kind_nxt = gcrm_pkg::KIND_CHECK_OFF;
              oidx_nxt = '0;
            end else if (!prev_vis) begin
              kind_nxt      = gcrm_pkg::KIND_NEVER;
              violation_nxt = 1'b1;
            end else begin
              gap_nxt = diff_t;
              if (diff_t >= TimeW'(limit)) begin
                kind_nxt      = gcrm_pkg::KIND_STALE;
                violation_nxt = 1'b1;
              end else begin
                kind_nxt = gcrm_pkg::KIND_OK;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      grid_side_r <= gcrm_pkg::GRID_SIDE_RST;
      max_gap_r   <= gcrm_pkg::MAX_GAP_RST;
      latest_r    <= '0;
      violation_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      grid_side_r <= grid_side_nxt;
      max_gap_r   <= max_gap_nxt;
      latest_r    <= latest_nxt;
      violation_r <= violation_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    time_r   <= time_nxt;
    neg_x_r  <= neg_x_nxt;
    neg_y_r  <= neg_y_nxt;
    mag_x_r  <= mag_x_nxt;
    mag_y_r  <= mag_y_nxt;
    q_x_r    <= q_x_nxt;
    q_y_r    <= q_y_nxt;
    back_x_r <= back_x_nxt;
    back_y_r <= back_y_nxt;
    off_r    <= off_nxt;
    slot_r   <= slot_nxt;
    idx_r    <= idx_nxt;
    kind_r   <= kind_nxt;
    oidx_r   <= oidx_nxt;
    gap_r    <= gap_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_cell_index    = oidx_r;
  assign out_gap_s         = gap_r;
  assign out_any_violation = violation_r;

  // The sticky violation flag never clears outside reset.
  assert property (@(posedge clk) disable iff (!rst_n) violation_r |=> violation_r)
    else $error("sticky violation flag cleared");

  // A new result appears only from the update step.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && !out_stall) || !out_valid_r |=>
                   !out_valid_r || $past(state_r == ST_UPD))
    else $error("result raised outside the update step");

  // Off-grid and never-visited results carry no gap.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && (kind_r == gcrm_pkg::KIND_OFF_GRID ||
                   kind_r == gcrm_pkg::KIND_CHECK_OFF || kind_r == gcrm_pkg::KIND_NEVER)
                   |-> gap_r == '0)
    else $error("gap reported on a result that has none");

  // Nothing is accepted while the cell store is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == ST_CLEAR |-> in_stall && !ram_we == 1'b0)
    else $error("transaction accepted during clearing pass");

endmodule

// ===== bench/gcrm_verdict_monitor.sv =====
// Result predictor and comparator for the grid cell revisit monitor.
`timescale 1ns / 1ps

module gcrm_verdict_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel, observed.
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [gcrm_pkg::POS_W-1:0]   in_pos_x_m,
  input  logic signed [gcrm_pkg::POS_W-1:0]   in_pos_y_m,
  input  logic [gcrm_pkg::TIME_W-1:0]         in_time_s,
  input  logic [gcrm_pkg::CHECK_W-1:0]        in_check_col,
  input  logic [gcrm_pkg::CHECK_W-1:0]        in_check_row,
  // Result channel, observed.
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [gcrm_pkg::KIND_W-1:0]         out_result_kind,
  input  logic [gcrm_pkg::INDEX_W-1:0]        out_cell_index,
  input  logic [gcrm_pkg::TIME_W-1:0]         out_gap_s,
  input  logic                                out_any_violation,
  // Configuration channel, observed.
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [gcrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Totals handed to the testbench top.
  output int                                  mismatch_count,
  output int                                  results_pending,
  output int                                  results_checked
);

  localparam int CELL_COUNT  = gcrm_pkg::GRID_SIDE_DEF * gcrm_pkg::GRID_SIDE_DEF;
  localparam int PRINT_LIMIT = 40;
  localparam int DUE_DEPTH   = 64;

  typedef struct packed {
    logic [gcrm_pkg::KIND_W-1:0]  kind;
    logic [gcrm_pkg::INDEX_W-1:0] index;
    logic [gcrm_pkg::TIME_W-1:0]  gap;
    logic                         violation;
  } cell_verdict_t;

  // Shadow copy of the cell store, the time high-water mark and the sticky flag.
  logic [gcrm_pkg::TIME_W-1:0]   last_seen_s [CELL_COUNT];
  bit                            visited_cell [CELL_COUNT];
  logic [gcrm_pkg::TIME_W-1:0]   newest_s;
  bit                            violation_sticky;
  logic [gcrm_pkg::SIDE_W-1:0]   side_cfg;
  logic [gcrm_pkg::GAPMIN_W-1:0] gap_min_cfg;

  // Expected results in order, kept in a ring.
  cell_verdict_t verdicts_due [DUE_DEPTH];
  int            due_wr;
  int            due_rd;
  int            bad_count;
  int            compared_count;

  // Works out the verdict for one accepted transaction and updates the shadow state.
  function automatic cell_verdict_t predict_verdict(
    input logic                                is_check,
    input logic signed [gcrm_pkg::POS_W-1:0]   pos_x,
    input logic signed [gcrm_pkg::POS_W-1:0]   pos_y,
    input logic [gcrm_pkg::TIME_W-1:0]         stamp,
    input logic [gcrm_pkg::CHECK_W-1:0]        col_in,
    input logic [gcrm_pkg::CHECK_W-1:0]        row_in
  );
    int                          side;
    int                          cx;
    int                          cy;
    int                          slot;
    longint unsigned             limit_s;
    logic [gcrm_pkg::TIME_W-1:0] prev;
    logic [gcrm_pkg::TIME_W-1:0] gap;
    cell_verdict_t               v;

    side    = (side_cfg > gcrm_pkg::GRID_SIDE_DEF) ? gcrm_pkg::GRID_SIDE_DEF : int'(side_cfg);
    limit_s = 64'(gap_min_cfg) * 64'd60;
    v       = '0;
    gap     = '0;

    if (!is_check) begin
      // Position report: truncating divide, then the bounds check.
      cx = int'(pos_x) / gcrm_pkg::CELL_METRES_DEF;
      cy = int'(pos_y) / gcrm_pkg::CELL_METRES_DEF;
      if (stamp > newest_s) newest_s = stamp;
      if (cx < 0 || cy < 0 || cx >= side || cy >= side) begin
        v.kind = gcrm_pkg::KIND_OFF_GRID;
      end else begin
        slot   = cy * gcrm_pkg::GRID_SIDE_DEF + cx;
        v.kind = gcrm_pkg::KIND_RECORDED;
        if (visited_cell[slot]) begin
          prev = last_seen_s[slot];
          gap  = (stamp > prev) ? stamp - prev : '0;
          if (gap >= limit_s) begin
            v.kind           = gcrm_pkg::KIND_GAP;
            violation_sticky = 1'b1;
          end
          if (stamp > prev) last_seen_s[slot] = stamp;
        end else begin
          visited_cell[slot] = 1'b1;
          last_seen_s[slot]  = stamp;
        end
        v.gap   = gap;
        v.index = gcrm_pkg::INDEX_W'(cy * side + cx);
      end
    end else begin
      // Cell check against the latest time seen so far.
      cx = int'(col_in);
      cy = int'(row_in);
      if (cx >= side || cy >= side) begin
        v.kind = gcrm_pkg::KIND_CHECK_OFF;
      end else begin
        slot    = cy * gcrm_pkg::GRID_SIDE_DEF + cx;
        v.index = gcrm_pkg::INDEX_W'(cy * side + cx);
        if (!visited_cell[slot]) begin
          violation_sticky = 1'b1;
          v.kind           = gcrm_pkg::KIND_NEVER;
        end else begin
          prev  = last_seen_s[slot];
          gap   = (newest_s > prev) ? newest_s - prev : '0;
          v.gap = gap;
          if (gap >= limit_s) begin
            violation_sticky = 1'b1;
            v.kind           = gcrm_pkg::KIND_STALE;
          end else begin
            v.kind = gcrm_pkg::KIND_OK;
          end
        end
      end
    end
    v.violation = violation_sticky;
    return v;
  endfunction

  // Compares one field of a result and reports a difference.
  function automatic void compare_field(input string field,
                                        input logic [gcrm_pkg::TIME_W-1:0] want,
                                        input logic [gcrm_pkg::TIME_W-1:0] got);
    if (want !== got) begin
      if (bad_count < PRINT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      bad_count++;
    end
  endfunction

  // Follow every channel on the clock edge; configuration first, then input, then output.
  always @(posedge clk) begin : track
    cell_verdict_t want;
    cell_verdict_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < CELL_COUNT; i++) visited_cell[i] = 1'b0;
      newest_s         = '0;
      violation_sticky = 1'b0;
      side_cfg         = gcrm_pkg::GRID_SIDE_RST;
      gap_min_cfg      = gcrm_pkg::MAX_GAP_RST;
      due_wr           = 0;
      due_rd           = 0;
      bad_count        = 0;
      compared_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcrm_pkg::REG_GRID_SIDE: side_cfg = cfg_wdata[gcrm_pkg::SIDE_W-1:0];
          gcrm_pkg::REG_MAX_GAP:   gap_min_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fresh = predict_verdict(in_command, in_pos_x_m, in_pos_y_m,
                                in_time_s, in_check_col, in_check_row);
        verdicts_due[due_wr % DUE_DEPTH] = fresh;
        due_wr++;
      end
      if (out_valid && !out_stall) begin
        if (due_wr == due_rd) begin
          if (bad_count < PRINT_LIMIT)
            $display("%0t ns: result with none expected, kind %0d index %0d gap %0d flag %0d",
                     $time, out_result_kind, out_cell_index, out_gap_s, out_any_violation);
          bad_count++;
        end else begin
          want = verdicts_due[due_rd % DUE_DEPTH];
          due_rd++;
          compared_count++;
          compare_field("result_kind", want.kind, out_result_kind);
          compare_field("cell_index", want.index, out_cell_index);
          compare_field("gap_s", want.gap, out_gap_s);
          compare_field("any_violation", want.violation, out_any_violation);
        end
      end
    end
    mismatch_count  <= bad_count;
    results_pending <= due_wr - due_rd;
    results_checked <= compared_count;
  end

endmodule

// ===== bench/tb_grid_cell_revisit_monitor_top.sv =====
// Testbench top for the grid cell revisit monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_grid_cell_revisit_monitor_top;

  localparam int IDLE_PCT    = 14;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOT_CELLS   = 12;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Register indexes that the block does not decode.
  localparam logic [gcrm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gcrm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic                                 in_command;
  logic signed [gcrm_pkg::POS_W-1:0]    in_pos_x_m;
  logic signed [gcrm_pkg::POS_W-1:0]    in_pos_y_m;
  logic [gcrm_pkg::TIME_W-1:0]          in_time_s;
  logic [gcrm_pkg::CHECK_W-1:0]         in_check_col;
  logic [gcrm_pkg::CHECK_W-1:0]         in_check_row;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [gcrm_pkg::KIND_W-1:0]          out_result_kind;
  logic [gcrm_pkg::INDEX_W-1:0]         out_cell_index;
  logic [gcrm_pkg::TIME_W-1:0]          out_gap_s;
  logic                                 out_any_violation;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [gcrm_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [gcrm_pkg::CFG_DATA_W-1:0]      cfg_wdata;

  int mismatch_count;
  int results_pending;
  int results_checked;

  // Stimulus state shared with the receiver process.
  logic                        jitter_on;
  int                          hold_ask;
  int                          hold_served;
  int                          eff_side;
  int                          limit_s;
  logic [gcrm_pkg::TIME_W-1:0] now_s;
  int                          hot_col [HOT_CELLS];
  int                          hot_row [HOT_CELLS];
  int                          n_reports;
  int                          n_checks;
  int                          n_writes;

  grid_cell_revisit_monitor_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_pos_x_m        (in_pos_x_m),
    .in_pos_y_m        (in_pos_y_m),
    .in_time_s         (in_time_s),
    .in_check_col      (in_check_col),
    .in_check_row      (in_check_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_cell_index    (out_cell_index),
    .out_gap_s         (out_gap_s),
    .out_any_violation (out_any_violation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  gcrm_verdict_monitor verdict_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_pos_x_m        (in_pos_x_m),
    .in_pos_y_m        (in_pos_y_m),
    .in_time_s         (in_time_s),
    .in_check_col      (in_check_col),
    .in_check_row      (in_check_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_cell_index    (out_cell_index),
    .out_gap_s         (out_gap_s),
    .out_any_violation (out_any_violation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending),
    .results_checked   (results_checked)
  );

  // Free-running clock, 8 ns period.
  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result receiver: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin : receiver
    out_stall   <= 1'b0;
    hold_served <= 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served <= hold_ask;
      end
      out_stall <= jitter_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Ends the run if no transaction moves on any channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_grid_cell_revisit_monitor_top: done, errors");
    $finish;
  end

  // Offers one transaction, with random idle cycles in front, and waits for acceptance.
  task automatic offer_item(input logic cmd, input logic signed [gcrm_pkg::POS_W-1:0] x,
                            input logic signed [gcrm_pkg::POS_W-1:0] y,
                            input logic [gcrm_pkg::TIME_W-1:0] t,
                            input logic [gcrm_pkg::CHECK_W-1:0] col,
                            input logic [gcrm_pkg::CHECK_W-1:0] row);
    while (jitter_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_pos_x_m   <= x;
    in_pos_y_m   <= y;
    in_time_s    <= t;
    in_check_col <= col;
    in_check_row <= row;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_CHECK) n_checks++;
    else n_reports++;
  endtask

  // Position report; the check fields carry noise.
  task automatic offer_report(input logic signed [gcrm_pkg::POS_W-1:0] x,
                              input logic signed [gcrm_pkg::POS_W-1:0] y,
                              input logic [gcrm_pkg::TIME_W-1:0] t);
    offer_item(CMD_REPORT, x, y, t, gcrm_pkg::CHECK_W'($urandom),
               gcrm_pkg::CHECK_W'($urandom));
  endtask

  // Cell check; position and time carry noise.
  task automatic offer_check(input logic [gcrm_pkg::CHECK_W-1:0] col,
                             input logic [gcrm_pkg::CHECK_W-1:0] row);
    offer_item(CMD_CHECK, gcrm_pkg::POS_W'($urandom), gcrm_pkg::POS_W'($urandom),
               {8'($urandom), 32'($urandom)}, col, row);
  endtask

  task automatic write_reg(input logic [gcrm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcrm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // Holds the input back until every outstanding result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Reconfigures the idle block and picks a fresh set of frequently visited cells.
  task automatic set_config(input int side, input int gap_min);
    int i;
    wait_for_results();
    write_reg(gcrm_pkg::REG_GRID_SIDE, gcrm_pkg::CFG_DATA_W'(side));
    write_reg(gcrm_pkg::REG_MAX_GAP, gcrm_pkg::CFG_DATA_W'(gap_min));
    eff_side = ((side & 'h1FF) > gcrm_pkg::GRID_SIDE_DEF) ? gcrm_pkg::GRID_SIDE_DEF :
               (side & 'h1FF);
    limit_s  = 60 * gap_min;
    for (i = 0; i < HOT_CELLS; i++) begin
      hot_col[i] = (eff_side > 0) ? $urandom_range(0, eff_side - 1) : 0;
      hot_row[i] = (eff_side > 0) ? $urandom_range(0, eff_side - 1) : 0;
    end
  endtask

  // A coordinate in metres that lands in cell c; cell 0 is also reached from below zero.
  function automatic logic signed [gcrm_pkg::POS_W-1:0] coord_in_cell(input int c);
    logic signed [gcrm_pkg::POS_W-1:0] v;
    if (c == 0 && $urandom_range(0, 1) == 1)
      v = gcrm_pkg::POS_W'(-int'($urandom_range(0, gcrm_pkg::CELL_METRES_DEF - 1)));
    else
      v = gcrm_pkg::POS_W'(c * gcrm_pkg::CELL_METRES_DEF +
                           int'($urandom_range(0, gcrm_pkg::CELL_METRES_DEF - 1)));
    return v;
  endfunction

  // One random phase under one setting: mostly ordered visits to a few cells and
  // checks of them, with some out-of-order times, grid-edge reports and noise.
  task automatic run_phase(input int side, input int gap_min, input int items,
                           input bit calm, input int hold_at, input bit late_clock);
    int                                k;
    int                                pick;
    int                                sel;
    int                                edge_cell;
    int                                back_s;
    logic [gcrm_pkg::TIME_W-1:0]       t;
    logic signed [gcrm_pkg::POS_W-1:0] x;
    logic signed [gcrm_pkg::POS_W-1:0] y;
    set_config(side, gap_min);
    jitter_on <= !calm;
    if (late_clock) now_s = 40'hFF_FFF0_0000;
    else now_s = now_s + gcrm_pkg::TIME_W'($urandom_range(0, 1 << 20));
    for (k = 0; k < items; k++) begin
      if (k == hold_at) hold_ask <= hold_ask + 1;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, HOT_CELLS - 1);
      if (pick < 60) begin
        x = coord_in_cell(hot_col[sel]);
        y = coord_in_cell(hot_row[sel]);
        if ($urandom_range(0, 29) == 0) begin
          back_s = $urandom_range(0, limit_s + 5);
          t = (now_s > gcrm_pkg::TIME_W'(back_s)) ? now_s - gcrm_pkg::TIME_W'(back_s) : '0;
        end else begin
          now_s = now_s + gcrm_pkg::TIME_W'($urandom_range(0, limit_s / 6 + 3));
          t     = now_s;
        end
        offer_report(x, y, t);
      end else if (pick < 85) begin
        offer_check(gcrm_pkg::CHECK_W'(hot_col[sel]), gcrm_pkg::CHECK_W'(hot_row[sel]));
      end else if (pick < 92) begin
        offer_check(gcrm_pkg::CHECK_W'($urandom), gcrm_pkg::CHECK_W'($urandom));
      end else if (pick < 97) begin
        edge_cell = eff_side - 1 + int'($urandom_range(0, 1));
        x = gcrm_pkg::POS_W'(edge_cell * gcrm_pkg::CELL_METRES_DEF +
                             int'($urandom_range(0, gcrm_pkg::CELL_METRES_DEF - 1)));
        y = coord_in_cell(hot_row[sel]);
        if ($urandom_range(0, 1) == 1) offer_report(y, x, now_s);
        else offer_report(x, y, now_s);
      end else begin
        offer_report(gcrm_pkg::POS_W'($urandom), gcrm_pkg::POS_W'($urandom), now_s);
      end
    end
    // The top of the time range, followed by checks against it.
    if (late_clock) begin
      offer_report(coord_in_cell(hot_col[0]), coord_in_cell(hot_row[0]), '1);
      offer_check(gcrm_pkg::CHECK_W'(hot_col[0]), gcrm_pkg::CHECK_W'(hot_row[0]));
      offer_check(gcrm_pkg::CHECK_W'(hot_col[1]), gcrm_pkg::CHECK_W'(hot_row[1]));
    end
  endtask

  // Reset, directed cases, random phases, drain and verdict.
  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_REPORT;
    in_pos_x_m   <= '0;
    in_pos_y_m   <= '0;
    in_time_s    <= '0;
    in_check_col <= '0;
    in_check_row <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= gcrm_pkg::REG_GRID_SIDE;
    cfg_wdata    <= '0;
    jitter_on    <= 1'b1;
    hold_ask     <= 0;
    now_s     = '0;
    n_reports = 0;
    n_checks  = 0;
    n_writes  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Default geometry: cell zero from both sides of the origin, the far corner,
    // just off the left and right edges, the coordinate extremes, the gap threshold
    // on both sides, a step back in time, a never-visited cell and a stale one.
    set_config(256, 5);
    offer_report(0, 0, 100);
    offer_report(-19, 19, 150);
    offer_check(0, 0);
    offer_report(5119, 5119, 160);
    offer_report(5120, 0, 165);
    offer_report(-20, 0, 165);
    offer_report(24'sh7FFFFF, 24'sh800000, 170);
    offer_report(24'sh800000, 24'sh7FFFFF, 170);
    offer_check(255, 255);
    offer_report(19, -19, 449);
    offer_report(0, 0, 749);
    offer_report(0, 0, 700);
    offer_check(0, 0);
    offer_check(3, 7);
    offer_report(2000, 40, 800);
    offer_check(255, 255);
    offer_report(2000, 40, 0);

    // Zero grid side, with writes to the undecoded indexes.
    set_config(0, 5);
    write_reg(REG_SPARE_A, gcrm_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, 16'hFFFF);
    offer_report(0, 0, 860);
    offer_check(0, 0);

    // A one-cell grid.
    set_config(1, 5);
    offer_report(19, 19, 900);
    offer_report(20, 0, 900);
    offer_check(1, 0);
    offer_check(0, 0);

    // A side of 100: the index uses the configured side.
    set_config(100, 5);
    offer_report(2000, 40, 950);
    offer_report(1999, 40, 950);
    now_s = 1000;

    run_phase(256, 5, 220, 1'b0, 60, 1'b0);
    run_phase(16, 1, 200, 1'b0, -1, 1'b0);
    run_phase(1, 0, 120, 1'b0, -1, 1'b0);
    run_phase(0, 3, 40, 1'b0, -1, 1'b0);
    run_phase(100, 65535, 220, 1'b0, -1, 1'b0);
    run_phase(511, 2, 200, 1'b1, -1, 1'b0);
    run_phase(300, 0, 150, 1'b0, -1, 1'b0);
    run_phase(8, 10, 200, 1'b0, -1, 1'b0);
    run_phase(256, 1, 200, 1'b0, -1, 1'b1);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d position reports and %0d cell checks across %0d register writes,",
             n_reports, n_checks, n_writes);
    $display("grid sides 0 to 511, gap limits 0 to 65535 minutes; %0d results compared.",
             results_checked);
    if (mismatch_count == 0 && results_pending == 0)
      $display("tb_grid_cell_revisit_monitor_top: done, clean");
    else
      $display("tb_grid_cell_revisit_monitor_top: done, errors");
    $finish;
  end

endmodule
